/* rtl/rsll_pkg.sv */
`default_nettype none

package rsll_pkg;

    localparam int OPND_BITS = 64;
    localparam int VALUE_BITS = 62;
    localparam int CFG_INDEX_BITS = 3;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_FOLD = 2'd1;
    localparam logic [1:0] CMD_SCALE = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_MODULUS = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LIMB_IN_INPUT = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_USE_GIVEN_FACTOR = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GIVEN_FACTOR = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INPUT_IN_COEFF_DOMAIN = 3'd4;

    localparam logic STATUS_OK = 1'b0;
    localparam logic STATUS_DOMAIN_ERROR = 1'b1;

    typedef struct packed {
        logic [1:0]            command;
        logic [OPND_BITS-1:0]  prime_value;
        logic [VALUE_BITS-1:0] coefficient;
        logic                  last_coefficient;
    } item_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] scaled_value;
        logic                  status;
        logic                  row_end;
    } result_t;

    typedef struct packed {
        logic limb_in_input;
        logic use_given_factor;
        logic input_in_coeff_domain;
    } cfg_flags_t;

endpackage

`default_nettype wire

/* rtl/rsll_cfg.sv */
`default_nettype none

module rsll_cfg #(
    parameter int W = 62
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [rsll_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [W-1:0]                        cfg_data,
    output logic [W-1:0]                             modulus,
    output logic [W-1:0]                             given_factor,
    output rsll_pkg::cfg_flags_t                     flags
);
    import rsll_pkg::*;

    logic [W-1:0] modulus_reg;
    logic [W-1:0] given_factor_reg;
    cfg_flags_t   flags_reg;

    assign cfg_ready = 1'b1;
    assign modulus = modulus_reg;
    assign given_factor = given_factor_reg;
    assign flags = flags_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= W'(2);
            given_factor_reg <= '0;
            flags_reg.limb_in_input <= 1'b0;
            flags_reg.use_given_factor <= 1'b0;
            flags_reg.input_in_coeff_domain <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MODULUS: modulus_reg <= cfg_data;
                CFG_LIMB_IN_INPUT: flags_reg.limb_in_input <= cfg_data[0];
                CFG_USE_GIVEN_FACTOR: flags_reg.use_given_factor <= cfg_data[0];
                CFG_GIVEN_FACTOR: given_factor_reg <= cfg_data;
                CFG_INPUT_IN_COEFF_DOMAIN: flags_reg.input_in_coeff_domain <= cfg_data[0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/rsll_modmul.sv */
`default_nettype none

module rsll_modmul #(
    parameter int W = 62
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [W-1:0]                   a,
    input  wire logic [rsll_pkg::OPND_BITS-1:0] b,
    input  wire logic [W-1:0]                   m,
    output logic                                done,
    output logic [W-1:0]                        product
);
    import rsll_pkg::*;

    localparam int XW = W + 3;
    localparam int CW = $clog2(OPND_BITS);

    typedef enum logic [4:0] {
        MM_IDLE = 5'b00001,
        MM_RED  = 5'b00010,
        MM_PREP = 5'b00100,
        MM_MUL  = 5'b01000,
        MM_DONE = 5'b10000
    } mm_state_t;

    mm_state_t            state_reg, state_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [W-1:0]         a_sh_reg, a_sh_next;
    logic [OPND_BITS-1:0] b_sh_reg, b_sh_next;
    logic [W-1:0]         r_reg, r_next;
    logic [W-1:0]         acc_reg, acc_next;
    logic signed [XW-1:0] nm_reg, nm_next;
    logic signed [XW-1:0] am_reg, am_next;
    logic signed [XW-1:0] a2m_reg, a2m_next;

    logic [W:0]           red_r2;
    logic [W+1:0]         red_diff;
    logic [W-1:0]         red_val;
    logic signed [XW-1:0] dbl;
    logic signed [XW-1:0] t1;
    logic signed [XW-1:0] t2;
    logic signed [XW-1:0] t3;
    logic signed [XW-1:0] t4;
    logic signed [XW-1:0] mul_sel;
    logic                 m_small;

    // Reduction of a: one bit of a enters the remainder each cycle.
    assign red_r2 = {r_reg, a_sh_reg[W-1]};
    assign red_diff = {1'b0, red_r2} - {2'b00, m};
    assign red_val = red_diff[W+1] ? red_r2[W-1:0] : red_diff[W-1:0];

    // Multiply step: all candidates of double-and-add are formed in parallel.
    assign dbl = {2'b00, acc_reg, 1'b0};
    assign t1 = dbl + nm_reg;
    assign t2 = dbl + {3'b000, r_reg};
    assign t3 = dbl + am_reg;
    assign t4 = dbl + a2m_reg;

    always_comb
    begin
        if (b_sh_reg[OPND_BITS-1])
        begin
            if (!t4[XW-1])
                mul_sel = t4;
            else if (!t3[XW-1])
                mul_sel = t3;
            else
                mul_sel = t2;
        end
        else
        begin
            if (!t1[XW-1])
                mul_sel = t1;
            else
                mul_sel = dbl;
        end
    end

    assign m_small = (m[W-1:1] == '0);
    assign done = (state_reg == MM_DONE);
    assign product = m_small ? '0 : acc_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        a_sh_next = a_sh_reg;
        b_sh_next = b_sh_reg;
        r_next = r_reg;
        acc_next = acc_reg;
        nm_next = nm_reg;
        am_next = am_reg;
        a2m_next = a2m_reg;
        case (state_reg)
            MM_IDLE:
            begin
                if (start)
                begin
                    a_sh_next = a;
                    b_sh_next = b;
                    r_next = '0;
                    cnt_next = CW'(W - 1);
                    state_next = MM_RED;
                end
            end
            MM_RED:
            begin
                r_next = red_val;
                a_sh_next = {a_sh_reg[W-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = MM_PREP;
            end
            MM_PREP:
            begin
                nm_next = {XW{1'b0}} - {3'b000, m};
                am_next = {3'b000, r_reg} - {3'b000, m};
                a2m_next = {3'b000, r_reg} - {2'b00, m, 1'b0};
                acc_next = '0;
                cnt_next = CW'(OPND_BITS - 1);
                state_next = MM_MUL;
            end
            MM_MUL:
            begin
                acc_next = mul_sel[W-1:0];
                b_sh_next = {b_sh_reg[OPND_BITS-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = MM_DONE;
            end
            MM_DONE:
            begin
                state_next = MM_IDLE;
            end
            default:
            begin
                state_next = MM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= MM_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        a_sh_reg <= a_sh_next;
        b_sh_reg <= b_sh_next;
        r_reg <= r_next;
        acc_reg <= acc_next;
        nm_reg <= nm_next;
        am_reg <= am_next;
        a2m_reg <= a2m_next;
    end

endmodule

`default_nettype wire

/* rtl/rns_scaled_limb_lift.sv */
// Channel  | Direction | Handshake                | Payload
// item     | in        | item_valid / item_stall  | rsll_pkg::item_t
// result   | out       | result_valid / result_stall | rsll_pkg::result_t
// cfg      | in        | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// Fold and scale commands run one bit-serial modular multiply: it reduces the factor bit
// by bit, takes one setup step, shifts through the 64-bit multiplier operand and ends in
// a done step. Clear, unused commands and scales that give zero skip the multiply.
// Reset is asynchronous, active low; the running factor resets to one.
// A finished result waits in the output register while the next item is taken.
`default_nettype none

module rns_scaled_limb_lift #(
    parameter int MODULUS_BITS = 62
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                item_valid,
    output logic                                     item_stall,
    input  wire rsll_pkg::item_t                     item,
    output logic                                     result_valid,
    input  wire logic                                result_stall,
    output rsll_pkg::result_t                        result,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [rsll_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [MODULUS_BITS-1:0]             cfg_data
);
    import rsll_pkg::*;

    localparam int W = MODULUS_BITS;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_BUSY = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t         state_reg, state_next;
    logic [W-1:0]   factor_reg, factor_next;
    logic           fold_reg, fold_next;
    logic           last_reg, last_next;
    logic [W-1:0]   value_reg, value_next;
    logic           status_reg, status_next;
    logic           result_valid_reg, result_valid_next;
    result_t        result_reg, result_next;

    logic [W-1:0]         modulus;
    logic [W-1:0]         given_factor;
    cfg_flags_t           flags;
    logic                 mm_start;
    logic [W-1:0]         mm_a;
    logic [OPND_BITS-1:0] mm_b;
    logic                 mm_done;
    logic [W-1:0]         mm_product;
    logic                 item_take;
    logic                 out_free;

    rsll_cfg #(
        .W(W)
    ) u_cfg (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .modulus(modulus),
        .given_factor(given_factor),
        .flags(flags)
    );

    rsll_modmul #(
        .W(W)
    ) u_modmul (
        .clk(clk),
        .rst_n(rst_n),
        .start(mm_start),
        .a(mm_a),
        .b(mm_b),
        .m(modulus),
        .done(mm_done),
        .product(mm_product)
    );

    assign item_stall = (state_reg != ST_IDLE);
    assign item_take = item_valid && !item_stall;
    assign out_free = !result_valid_reg || !result_stall;
    assign result_valid = result_valid_reg;
    assign result = result_reg;

    always_comb
    begin
        state_next = state_reg;
        factor_next = factor_reg;
        fold_next = fold_reg;
        last_next = last_reg;
        value_next = value_reg;
        status_next = status_reg;
        result_valid_next = result_valid_reg && result_stall;
        result_next = result_reg;
        mm_start = 1'b0;
        mm_a = factor_reg;
        mm_b = item.prime_value;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_take)
                begin
                    last_next = item.last_coefficient;
                    case (item.command)
                        CMD_CLEAR:
                        begin
                            factor_next = W'(1);
                        end
                        CMD_FOLD:
                        begin
                            mm_start = 1'b1;
                            fold_next = 1'b1;
                            state_next = ST_BUSY;
                        end
                        CMD_SCALE:
                        begin
                            fold_next = 1'b0;
                            value_next = '0;
                            status_next = STATUS_OK;
                            if (!flags.input_in_coeff_domain)
                            begin
                                status_next = STATUS_DOMAIN_ERROR;
                                state_next = ST_EMIT;
                            end
                            else if (!flags.limb_in_input)
                            begin
                                state_next = ST_EMIT;
                            end
                            else
                            begin
                                mm_start = 1'b1;
                                mm_a = flags.use_given_factor ? given_factor : factor_reg;
                                mm_b = OPND_BITS'(item.coefficient);
                                state_next = ST_BUSY;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_BUSY:
            begin
                if (mm_done)
                begin
                    if (fold_reg)
                    begin
                        factor_next = mm_product;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        value_next = mm_product;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    result_next.scaled_value = VALUE_BITS'(value_reg);
                    result_next.status = status_reg;
                    result_next.row_end = last_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            factor_reg <= W'(1);
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            factor_reg <= factor_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fold_reg <= fold_next;
        last_reg <= last_next;
        value_reg <= value_next;
        status_reg <= status_next;
        result_reg <= result_next;
    end

endmodule

`default_nettype wire
